[rtl/core/tlrp_pkg.sv]
// Package for the transaction log record parser.
// Request and result payload types, record kind codes, the front-to-back event type.
// No dependencies.
`default_nettype none

package tlrp_pkg;

	// record kinds
	localparam logic [1:0] KIND_TUPLE_HDR = 2'd0;
	localparam logic [1:0] KIND_INDEX     = 2'd1;
	localparam logic [1:0] KIND_TUPLE_END = 2'd2;
	localparam logic [1:0] KIND_ERROR     = 2'd3;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_of_txn;
		logic [55:0] origin_lsn;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [63:0] commit_stamp;
		logic [63:0] row_key;
		logic [15:0] shard_num;
		logic [15:0] tbl_num;
		logic [1:0]  access_type;
		logic [3:0]  index_op;
		logic [27:0] index_id;
		logic [7:0]  prev_buf_id;
		logic [55:0] prev_lsn;
		logic [55:0] record_lsn;
		logic        last_in_txn;
	} rec_item_t;

	// one classified event from the parser front end
	typedef struct packed {
		logic [1:0]  kind;
		logic        last;
		logic [63:0] commit_stamp;
		logic [63:0] key;
		logic [15:0] shard;
		logic [15:0] tbl_num;
		logic [3:0]  op_nibble;
		logic [63:0] aux;       // index word in [63:32], or previous-version word
		logic [55:0] base_lsn;
		logic [55:0] lsn_off;   // byte offset within the transaction
	} event_t;

endpackage

`default_nettype wire

[rtl/core/tlrp_front.sv]
// Parser front end: walks the little-endian log fields one byte per cycle while acc is high.
// Emits one registered event per byte at most. Depends on tlrp_pkg.
`default_nettype none

module tlrp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               acc,
	input  wire tlrp_pkg::byte_item_t item,
	output logic                    ev_valid,
	output tlrp_pkg::event_t        ev
);
	import tlrp_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SIZE, PH_COMMIT, PH_KEY, PH_META, PH_INDEX,
		PH_PREV, PH_PTR, PH_AO, PH_MINTS, PH_MAXTS, PH_BODY
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  bcnt_q, bcnt_d;
	logic [63:0] shift_q, shift_d;
	logic [63:0] len_q, len_d;
	logic [63:0] off_q, off_d;
	logic [55:0] base_q, base_d;
	logic [63:0] commit_q, commit_d;
	logic [63:0] key_q, key_d;
	logic [63:0] meta_q, meta_d;
	logic [9:0]  ileft_q, ileft_d;
	logic [15:0] bleft_q, bleft_d;
	logic [63:0] tstart_q, tstart_d;
	logic        ev_valid_q, ev_valid_d;
	event_t      ev_q, ev_d;

	always_comb begin
		phase_t      ph;
		logic [2:0]  need;
		logic [63:0] sh_n;
		logic [63:0] off_n;
		logic        finish;
		logic        last;

		ph = phase_q;
		phase_d = phase_q;
		bcnt_d = bcnt_q;
		shift_d = shift_q;
		len_d = len_q;
		off_d = off_q;
		base_d = base_q;
		commit_d = commit_q;
		key_d = key_q;
		meta_d = meta_q;
		ileft_d = ileft_q;
		bleft_d = bleft_q;
		tstart_d = tstart_q;
		ev_valid_d = 1'b0;
		finish = 1'b0;
		last = 1'b0;
		sh_n = {item.data_byte, shift_q[63:8]};
		off_n = off_q + 64'd1;
		need = 3'd7;

		ev_d.kind = KIND_ERROR;
		ev_d.last = 1'b0;
		ev_d.commit_stamp = commit_q;
		ev_d.key = key_q;
		ev_d.shard = meta_q[63:48];
		ev_d.tbl_num = meta_q[47:32];
		ev_d.op_nibble = meta_q[31:28];
		ev_d.aux = sh_n;
		ev_d.base_lsn = base_q;
		ev_d.lsn_off = tstart_q[55:0];

		if (acc) begin
			// a new transaction restarts parsing from the size field
			if (item.first_of_txn) begin
				ph = PH_SIZE;
				bcnt_d = 3'd0;
				base_d = item.origin_lsn;
				sh_n = {item.data_byte, 56'd0};
				off_n = 64'd1;
				ev_d.base_lsn = item.origin_lsn;
			end
			phase_d = ph;
			if (ph != PH_IDLE) begin
				shift_d = sh_n;
				off_d = off_n;
				if (ph == PH_BODY) begin
					bleft_d = bleft_q - 16'd1;
					finish = (bleft_d == 16'd0);
				end else begin
					need = (ph == PH_INDEX) ? 3'd3 : 3'd7;
					if (bcnt_d != need) begin
						bcnt_d = bcnt_d + 3'd1;
					end else begin
						bcnt_d = 3'd0;
						case (ph)
							PH_SIZE: begin
								len_d = sh_n;
								if (sh_n == 64'd0) begin
									ev_valid_d = 1'b1;
									ev_d.kind = KIND_ERROR;
									phase_d = PH_IDLE;
								end else begin
									phase_d = PH_COMMIT;
								end
							end
							PH_COMMIT: begin
								commit_d = sh_n;
								if (off_n < len_q) begin
									tstart_d = off_n;
									phase_d = PH_KEY;
								end else begin
									phase_d = PH_IDLE;
								end
							end
							PH_KEY: begin
								key_d = sh_n;
								phase_d = PH_META;
							end
							PH_META: begin
								meta_d = sh_n;
								if (sh_n[31:28] == 4'd0) begin
									ev_valid_d = 1'b1;
									ev_d.kind = KIND_ERROR;
									phase_d = PH_IDLE;
								end else begin
									ileft_d = sh_n[11:2];
									bleft_d = sh_n[27:12];
									phase_d = (sh_n[11:2] != 10'd0) ? PH_INDEX : PH_PREV;
								end
							end
							PH_INDEX: begin
								ev_valid_d = 1'b1;
								ev_d.kind = KIND_INDEX;
								ileft_d = ileft_q - 10'd1;
								if (ileft_d == 10'd0) begin
									phase_d = PH_PREV;
								end
							end
							PH_PREV: begin
								ev_valid_d = 1'b1;
								ev_d.kind = KIND_TUPLE_HDR;
								phase_d = PH_PTR;
							end
							PH_PTR:   phase_d = PH_AO;
							PH_AO:    phase_d = PH_MINTS;
							PH_MINTS: phase_d = PH_MAXTS;
							PH_MAXTS: begin
								if (bleft_q == 16'd0) begin
									finish = 1'b1;
								end else begin
									phase_d = PH_BODY;
								end
							end
							default: phase_d = PH_IDLE;
						endcase
					end
				end
				if (finish) begin
					last = (off_n >= len_q);
					ev_valid_d = 1'b1;
					ev_d.kind = KIND_TUPLE_END;
					ev_d.last = last;
					ev_d.lsn_off = off_n[55:0];
					if (last) begin
						phase_d = PH_IDLE;
					end else begin
						tstart_d = off_n;
						phase_d = PH_KEY;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bcnt_q <= '0;
			shift_q <= '0;
			len_q <= '0;
			off_q <= '0;
			base_q <= '0;
			commit_q <= '0;
			key_q <= '0;
			meta_q <= '0;
			ileft_q <= '0;
			bleft_q <= '0;
			tstart_q <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bcnt_q <= bcnt_d;
			shift_q <= shift_d;
			len_q <= len_d;
			off_q <= off_d;
			base_q <= base_d;
			commit_q <= commit_d;
			key_q <= key_d;
			meta_q <= meta_d;
			ileft_q <= ileft_d;
			bleft_q <= bleft_d;
			tstart_q <= tstart_d;
			ev_valid_q <= ev_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ev_q <= ev_d;
	end

	assign ev_valid = ev_valid_q;
	assign ev = ev_q;

endmodule

`default_nettype wire

[rtl/core/tlrp_queue.sv]
// Event queue between parser front end and result back end.
// Small circular buffer of tlrp_pkg::event_t entries with an occupancy count.
`default_nettype none

module tlrp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire tlrp_pkg::event_t          push_data,
	input  wire logic                      pop,
	output logic                           pop_valid,
	output tlrp_pkg::event_t               pop_data,
	output logic [$clog2(DEPTH+1)-1:0]     count
);
	import tlrp_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	event_t          entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign count = count_q;

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == CW'(DEPTH)))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

	a_count_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("count did not drop on pop");

endmodule

`default_nettype wire

[rtl/core/tlrp_back.sv]
// Result back end: formats queued events into result items.
// Holds the output register; lsn add and field extraction. Depends on tlrp_pkg.
`default_nettype none

module tlrp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pop_valid,
	input  wire tlrp_pkg::event_t    pop_data,
	output logic                     pop,
	output logic                     rec_valid,
	input  wire logic                rec_stall,
	output tlrp_pkg::rec_item_t      rec_data
);
	import tlrp_pkg::*;

	logic      out_valid_q;
	rec_item_t out_q;
	rec_item_t fmt;

	// highest set bit of the op nibble
	function automatic logic [1:0] access_of(input logic [3:0] n);
		if (n[3]) return 2'd3;
		if (n[2]) return 2'd2;
		if (n[1]) return 2'd1;
		return 2'd0;
	endfunction

	always_comb begin
		fmt = '0;
		fmt.record_kind = pop_data.kind;
		if (pop_data.kind != KIND_ERROR) begin
			fmt.commit_stamp = pop_data.commit_stamp;
			fmt.row_key = pop_data.key;
			fmt.shard_num = pop_data.shard;
			fmt.tbl_num = pop_data.tbl_num;
			fmt.access_type = access_of(pop_data.op_nibble);
		end
		case (pop_data.kind)
			KIND_TUPLE_HDR: begin
				fmt.prev_buf_id = pop_data.aux[63:56];
				fmt.prev_lsn = pop_data.aux[55:0];
				fmt.record_lsn = pop_data.base_lsn + pop_data.lsn_off;
			end
			KIND_INDEX: begin
				fmt.index_op = pop_data.aux[63:60];
				fmt.index_id = pop_data.aux[59:32];
			end
			KIND_TUPLE_END: begin
				fmt.record_lsn = pop_data.base_lsn + pop_data.lsn_off;
				fmt.last_in_txn = pop_data.last;
			end
			default: ;
		endcase
	end

	assign pop = pop_valid && (!out_valid_q || !rec_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !rec_stall) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= fmt;
		end
	end

	assign rec_valid = out_valid_q;
	assign rec_data = out_q;

endmodule

`default_nettype wire

[rtl/core/txn_log_record_parser_top.sv]
// Top level of the transaction log record parser.
// Front end, event queue and back end; uses tlrp_pkg, tlrp_front, tlrp_queue, tlrp_back.
//
//   channel   dir   handshake              payload
//   byte      in    byte_valid/byte_stall  tlrp_pkg::byte_item_t, one log byte per request
//   rec       out   rec_valid/rec_stall    tlrp_pkg::rec_item_t, zero or one per byte
//
// Cycles: one log byte per clock while byte_stall is low; a result passes the front
//   register, the queue and the output register after its byte.
// The front end is a byte-at-a-time field walker; its compare on the 64-bit offset
//   and the back end's 56-bit lsn add set the clock.
// Reset: arst_n clears parse state, queue pointers and the output valid; no clearing pass.
// Stalls: byte_stall rises once the queue plus the event in flight would fill it, so the
//   front end keeps running while rec_stall holds a finished result.
`default_nettype none

module txn_log_record_parser_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire tlrp_pkg::byte_item_t byte_data,
	output logic                      rec_valid,
	input  wire logic                 rec_stall,
	output tlrp_pkg::rec_item_t       rec_data
);
	import tlrp_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          byte_acc;
	logic          ev_valid;
	event_t        ev;
	logic          q_pop;
	logic          q_valid;
	event_t        q_data;
	logic [CW-1:0] q_count;
	logic [CW:0]   in_flight;

	// queue entries plus the event the front end registered this cycle
	assign in_flight = {1'b0, q_count} + {{CW{1'b0}}, ev_valid};
	assign byte_stall = (in_flight >= (CW + 1)'(QUEUE_DEPTH));
	assign byte_acc = byte_valid && !byte_stall;

	tlrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (byte_acc),
		.item     (byte_data),
		.ev_valid (ev_valid),
		.ev       (ev)
	);

	tlrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_valid),
		.push_data (ev),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data),
		.count     (q_count)
	);

	tlrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_valid),
		.pop_data  (q_data),
		.pop       (q_pop),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data)
	);

endmodule

`default_nettype wire

[bench/txn_log_record_checker.sv]
// Scoreboard for the transaction log record parser: predicts records from accepted
// log bytes and compares them with accepted records, field by field.
// Depends on tlrp_pkg.
`timescale 1ns / 100ps

module txn_log_record_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	input  wire logic                 byte_stall,
	input  wire tlrp_pkg::byte_item_t byte_data,
	input  wire logic                 rec_valid,
	input  wire logic                 rec_stall,
	input  wire tlrp_pkg::rec_item_t  rec_data,
	output int                        mismatches,
	output int                        outstanding
);
	import tlrp_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_SIZE, P_COMMIT, P_KEY, P_META, P_INDEX, P_PREV,
		P_PTR, P_AO, P_MINTS, P_MAXTS, P_BODY
	} parse_phase_t;

	parse_phase_t phase;
	logic [2:0]   field_byte;
	logic [63:0]  shift_reg;
	logic [63:0]  txn_len;
	logic [63:0]  txn_off;
	logic [55:0]  base_lsn;
	logic [63:0]  txn_cts;
	logic [63:0]  tuple_pk;
	logic [63:0]  tuple_meta;
	logic [9:0]   idx_left;
	logic [15:0]  body_left;
	logic [63:0]  tuple_off;

	rec_item_t pending_records[$];

	// fields shared by every tuple-related record
	function automatic rec_item_t tuple_record(input logic [1:0] kind);
		rec_item_t r;
		logic [3:0] op;
		r = '0;
		op = tuple_meta[31:28];
		r.record_kind  = kind;
		r.commit_stamp = txn_cts;
		r.row_key      = tuple_pk;
		r.shard_num    = tuple_meta[63:48];
		r.tbl_num      = tuple_meta[47:32];
		r.access_type  = op[3] ? 2'd3 : op[2] ? 2'd2 : op[1] ? 2'd1 : 2'd0;
		return r;
	endfunction

	task automatic flag_format_error();
		rec_item_t r;
		r = '0;
		r.record_kind = KIND_ERROR;
		pending_records.push_back(r);
		phase = P_IDLE;
	endtask

	task automatic close_tuple();
		rec_item_t r;
		r = tuple_record(KIND_TUPLE_END);
		r.record_lsn  = base_lsn + txn_off[55:0];
		r.last_in_txn = (txn_off >= txn_len);
		pending_records.push_back(r);
		if (r.last_in_txn) begin
			phase = P_IDLE;
		end else begin
			tuple_off = txn_off;
			phase = P_KEY;
		end
	endtask

	task automatic parse_log_byte(input byte_item_t it);
		rec_item_t  r;
		logic [2:0] last_byte;
		if (it.first_of_txn) begin
			phase = P_SIZE;
			field_byte = '0;
			shift_reg = '0;
			txn_off = '0;
			base_lsn = it.origin_lsn;
		end
		if (phase == P_IDLE)
			return;
		shift_reg = {it.data_byte, shift_reg[63:8]};
		txn_off = txn_off + 64'd1;
		if (phase == P_BODY) begin
			body_left = body_left - 16'd1;
			if (body_left == 16'd0)
				close_tuple();
			return;
		end
		last_byte = (phase == P_INDEX) ? 3'd3 : 3'd7;
		if (field_byte != last_byte) begin
			field_byte = field_byte + 3'd1;
			return;
		end
		field_byte = '0;
		case (phase)
			P_SIZE: begin
				txn_len = shift_reg;
				if (txn_len == 64'd0)
					flag_format_error();
				else
					phase = P_COMMIT;
			end
			P_COMMIT: begin
				txn_cts = shift_reg;
				if (txn_off < txn_len) begin
					tuple_off = txn_off;
					phase = P_KEY;
				end else begin
					phase = P_IDLE;
				end
			end
			P_KEY: begin
				tuple_pk = shift_reg;
				phase = P_META;
			end
			P_META: begin
				tuple_meta = shift_reg;
				if (shift_reg[31:28] == 4'd0) begin
					flag_format_error();
				end else begin
					idx_left = shift_reg[11:2];
					body_left = shift_reg[27:12];
					phase = (idx_left != 10'd0) ? P_INDEX : P_PREV;
				end
			end
			P_INDEX: begin
				r = tuple_record(KIND_INDEX);
				r.index_op = shift_reg[63:60];
				r.index_id = shift_reg[59:32];
				pending_records.push_back(r);
				idx_left = idx_left - 10'd1;
				if (idx_left == 10'd0)
					phase = P_PREV;
			end
			P_PREV: begin
				r = tuple_record(KIND_TUPLE_HDR);
				r.prev_buf_id = shift_reg[63:56];
				r.prev_lsn    = shift_reg[55:0];
				r.record_lsn  = base_lsn + tuple_off[55:0];
				pending_records.push_back(r);
				phase = P_PTR;
			end
			P_PTR:   phase = P_AO;
			P_AO:    phase = P_MINTS;
			P_MINTS: phase = P_MAXTS;
			P_MAXTS: begin
				if (body_left == 16'd0)
					close_tuple();
				else
					phase = P_BODY;
			end
			default: phase = P_IDLE;
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rec_item_t want;
		if (!arst_n) begin
			mismatches = 0;
			phase = P_IDLE;
			field_byte = '0;
			shift_reg = '0;
			txn_len = '0;
			txn_off = '0;
			base_lsn = '0;
			txn_cts = '0;
			tuple_pk = '0;
			tuple_meta = '0;
			idx_left = '0;
			body_left = '0;
			tuple_off = '0;
			pending_records.delete();
		end else begin
			if (byte_valid && !byte_stall)
				parse_log_byte(byte_data);
			if (rec_valid && !rec_stall) begin
				if (pending_records.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected record, expected none, got %h", $time, rec_data);
				end else begin
					want = pending_records.pop_front();
					check_field("record_kind", 64'(want.record_kind),
						64'(rec_data.record_kind));
					check_field("commit_stamp", want.commit_stamp, rec_data.commit_stamp);
					check_field("row_key", want.row_key, rec_data.row_key);
					check_field("shard_num", 64'(want.shard_num), 64'(rec_data.shard_num));
					check_field("tbl_num", 64'(want.tbl_num), 64'(rec_data.tbl_num));
					check_field("access_type", 64'(want.access_type),
						64'(rec_data.access_type));
					check_field("index_op", 64'(want.index_op), 64'(rec_data.index_op));
					check_field("index_id", 64'(want.index_id), 64'(rec_data.index_id));
					check_field("prev_buf_id", 64'(want.prev_buf_id),
						64'(rec_data.prev_buf_id));
					check_field("prev_lsn", 64'(want.prev_lsn), 64'(rec_data.prev_lsn));
					check_field("record_lsn", 64'(want.record_lsn),
						64'(rec_data.record_lsn));
					check_field("last_in_txn", 64'(want.last_in_txn),
						64'(rec_data.last_in_txn));
				end
			end
		end
		outstanding = pending_records.size();
	end

endmodule

[bench/txn_log_record_parser_top_tb.sv]
// Testbench top for the transaction log record parser: builds log transactions,
// drives the byte channel, stalls the record channel and gives the verdict.
// Depends on tlrp_pkg, txn_log_record_parser_top and txn_log_record_checker.
`timescale 1ns / 100ps

module txn_log_record_parser_top_tb;
	import tlrp_pkg::*;

	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off to fill the queue
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving on either side
	localparam int TOTAL_BYTES    = 1450;
	localparam int CALM_BYTES     = 1300;  // past this, no more idling on either side

	// how a tuple's free fields get filled
	localparam logic [1:0] FILL_RANDOM = 2'd0;
	localparam logic [1:0] FILL_ONES   = 2'd1;
	localparam logic [1:0] FILL_ZEROS  = 2'd2;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	byte_item_t byte_data;
	logic       rec_valid;
	logic       rec_stall;
	rec_item_t  rec_data;

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;
	int sent_bytes = 0;

	bit gaps_on   = 1'b0;
	bit stalls_on = 1'b0;
	bit hold_req  = 1'b0;

	// tuple bytes of the transaction under construction
	logic [7:0] tuple_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	txn_log_record_parser_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_data   (rec_data)
	);

	txn_log_record_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.rec_data    (rec_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic logic [63:0] pick64(input logic [1:0] fill);
		case (fill)
			FILL_ONES:  return '1;
			FILL_ZEROS: return '0;
			default:    return {$urandom, $urandom};
		endcase
	endfunction

	// One byte request; valid stays high afterwards unless the next call opens a gap.
	// origin_lsn carries noise on bytes that do not start a transaction.
	task automatic send_byte(input logic [7:0] b, input logic first, input logic [55:0] lsn);
		byte_item_t  it;
		logic [63:0] noise;
		noise = pick64(FILL_RANDOM);
		it.data_byte = b;
		it.first_of_txn = first;
		it.origin_lsn = first ? lsn : noise[55:0];
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
	endtask

	task automatic put_field(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++)
			tuple_q.push_back(v[8*i +: 8]);
	endtask

	// key, access word, index entries, previous-version word, four skipped words, body
	task automatic put_tuple(input logic [3:0] op, input logic [11:0] idx_bytes,
			input logic [15:0] body_len, input logic [1:0] fill);
		logic [63:0] shard_w;
		logic [63:0] tbl_w;
		logic [63:0] entry;
		shard_w = pick64(fill);
		tbl_w = pick64(fill);
		put_field(pick64(fill), 8);
		put_field({shard_w[15:0], tbl_w[15:0], op, body_len, idx_bytes}, 8);
		for (int i = 0; i < int'(idx_bytes >> 2); i++) begin
			entry = pick64(fill);
			// mostly insert / delete ops, now and then any nibble
			if (fill == FILL_RANDOM && $urandom_range(0, 3) != 0)
				entry[31:28] = $urandom_range(0, 1) ? 4'h4 : 4'h8;
			put_field(entry, 4);
		end
		put_field(pick64(fill), 8);
		repeat (4) put_field(pick64(FILL_RANDOM), 8);
		repeat (body_len) tuple_q.push_back(8'($urandom));
	endtask

	// size word, commit timestamp, then whatever tuple bytes were queued
	task automatic send_txn(input logic [63:0] size, input logic [55:0] lsn,
			input logic [1:0] fill);
		logic [63:0] cts;
		cts = pick64(fill);
		for (int i = 0; i < 8; i++)
			send_byte(size[8*i +: 8], i == 0, lsn);
		for (int i = 0; i < 8; i++)
			send_byte(cts[8*i +: 8], 1'b0, '0);
		foreach (tuple_q[i])
			send_byte(tuple_q[i], 1'b0, '0);
		sent_bytes += 16 + tuple_q.size();
		tuple_q.delete();
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		rec_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rec_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rec_stall <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				rec_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				rec_stall <= 1'b0;
			end
		end
	end

	// Watchdog: no request moving on either channel for too long ends the run.
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (rec_valid && !rec_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int          kind;
		int          ntup;
		int          cut;
		logic [3:0]  op;
		logic [11:0] idx;
		logic [15:0] body;
		logic [63:0] size;
		logic [63:0] rnd;
		logic [55:0] lsn;

		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// stray bytes while idle are ignored
		repeat (3) send_byte(8'($urandom), 1'b0, '0);
		// zero size: error record
		send_txn(64'd0, 56'h12_3456, FILL_RANDOM);
		// size covers only the header: no tuples, no records
		send_txn(64'd16, 56'h0, FILL_RANDOM);
		send_txn(64'd5, 56'h55, FILL_RANDOM);
		// plain tuple, no index entries, empty body, lsn zero
		put_tuple(4'h1, 12'd0, 16'd0, FILL_RANDOM);
		send_txn(64'd16 + tuple_q.size(), 56'h0, FILL_RANDOM);
		// all-ones fields, three index entries, lsn wraps past 2^56
		put_tuple(4'h8, 12'd12, 16'd3, FILL_ONES);
		send_txn(64'd16 + tuple_q.size(), '1, FILL_ONES);
		// two tuples; index byte counts not a multiple of four; all-zero fields in the first
		put_tuple(4'h2, 12'd7, 16'd1, FILL_ZEROS);
		put_tuple(4'h4, 12'd5, 16'd2, FILL_RANDOM);
		send_txn(64'd16 + tuple_q.size(), 56'h00ff_0000_0000_0000, FILL_ZEROS);
		// op nibble not one-hot
		put_tuple(4'hf, 12'd0, 16'd1, FILL_RANDOM);
		put_tuple(4'h6, 12'd4, 16'd0, FILL_RANDOM);
		send_txn(64'd16 + tuple_q.size(), 56'h77, FILL_RANDOM);
		// zero op nibble: error, rest of the transaction ignored
		put_tuple(4'h0, 12'd4, 16'd2, FILL_RANDOM);
		send_txn(64'd16 + tuple_q.size(), 56'h1000, FILL_RANDOM);
		// tuple overruns the size: first tuple end is marked last
		put_tuple(4'h1, 12'd0, 16'd4, FILL_RANDOM);
		put_tuple(4'h2, 12'd0, 16'd4, FILL_RANDOM);
		send_txn(64'd36, 56'h2000, FILL_RANDOM);
		// huge size: parser runs into a new tuple and gets restarted mid-parse
		put_tuple(4'h4, 12'd0, 16'd0, FILL_RANDOM);
		send_txn('1, 56'h3000, FILL_RANDOM);
		// transaction cut short inside the body, restarted by the next one
		put_tuple(4'h8, 12'd8, 16'd10, FILL_RANDOM);
		size = 64'd16 + tuple_q.size();
		repeat (5) void'(tuple_q.pop_back());
		send_txn(size, 56'h4000, FILL_RANDOM);

		// ---- long hold-off: receiver stops while bytes keep coming ----
		hold_req = 1'b1;
		repeat (3) put_tuple(4'h1 << $urandom_range(0, 3), 12'd12, 16'd0, FILL_RANDOM);
		rnd = pick64(FILL_RANDOM);
		send_txn(64'd16 + tuple_q.size(), rnd[55:0], FILL_RANDOM);

		// ---- random part ----
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		while (sent_bytes < TOTAL_BYTES) begin
			if (sent_bytes > CALM_BYTES) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			kind = $urandom_range(0, 19);
			ntup = $urandom_range(1, 3);
			for (int t = 0; t < ntup; t++) begin
				op = 4'h1 << $urandom_range(0, 3);
				if (kind == 13)
					op = 4'($urandom_range(1, 15));
				if (kind == 14 && t == ntup - 1)
					op = 4'h0;
				idx = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(16, 40))
				                                  : 12'($urandom_range(0, 15));
				body = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
				put_tuple(op, idx, body, FILL_RANDOM);
			end
			size = 64'd16 + tuple_q.size();
			case (kind)
				15: size = 64'd16 + $urandom_range(0, tuple_q.size() - 1);  // overrun
				16: size = size + $urandom_range(1, 200);                    // runs past the end
				17: size = 64'($urandom_range(0, 16));                        // no room, or zero
				18: size = pick64(FILL_RANDOM);
				19: begin
					// cut short; the next transaction restarts the parser
					cut = $urandom_range(1, tuple_q.size() - 1);
					repeat (cut) void'(tuple_q.pop_back());
				end
				default: ;
			endcase
			rnd = pick64(FILL_RANDOM);
			lsn = rnd[55:0];
			if ($urandom_range(0, 7) == 0)
				lsn = '1 - 56'($urandom_range(0, 200));  // near the lsn wrap
			send_txn(size, lsn, FILL_RANDOM);
			// stray bytes between transactions; not counted
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0, '0);
		end
		byte_valid <= 1'b0;

		// drain, then give late or extra records time to show up
		do @(negedge clk); while (outstanding != 0);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
